[hdl/mode_s_lcb_brute_force_correct_unit_macros.svh]
// ---------------------------------------------------------------------------
// Mode S LCB correction assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef MODE_S_LCB_BRUTE_FORCE_CORRECT_UNIT_MACROS_SVH
`define MODE_S_LCB_BRUTE_FORCE_CORRECT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset
`define MSLCB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never occurs outside reset
`define MSLCB_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MSLCB_ASSERT(lbl, clk, rstn, prop, msg)
`define MSLCB_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[hdl/mslcb_pkg.sv]
// ---------------------------------------------------------------------------
// Mode S LCB correction package
// Field widths, status codes, queued job layout and the CRC parity table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mslcb_pkg;

  localparam int LCB_N      = 4;    // position fields per frame
  localparam int MAX_LCB    = 4;    // positions searched at most
  localparam int FRAME_BITS = 112;
  localparam int HALF_W     = 56;
  localparam int SYN_W      = 24;
  localparam int POS_W      = 7;
  localparam int CNT_IN_W   = 4;
  localparam int CNT_W      = $clog2(LCB_N + 1);
  localparam int QDEPTH     = 2;    // power of two
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_NO_ERROR    = 3'd0,
    ST_TOO_MANY    = 3'd1,
    ST_NO_SOLUTION = 3'd2,
    ST_MULTIPLE    = 3'd3,
    ST_FOUND       = 3'd4
  } status_t;

  // One classified request on its way to the search engine
  typedef struct packed {
    logic                             search;  // run the subset search
    status_t                          status;  // final status when no search
    logic [CNT_W-1:0]                 count;
    logic [LCB_N-1:0][SYN_W-1:0]      words;
    logic [LCB_N-1:0][POS_W-1:0]      pos;
    logic [SYN_W-1:0]                 syndrome;
    logic [HALF_W-1:0]                hi;
    logic [HALF_W-1:0]                lo;
  } job_t;

  localparam logic [SYN_W-1:0] CRC_TABLE [FRAME_BITS] = '{
    24'h3935ea, 24'h1c9af5, 24'hf1b77e, 24'h78dbbf, 24'hc397db, 24'h9e31e9, 24'hb0e2f0,
    24'h587178, 24'h2c38bc, 24'h161c5e, 24'h0b0e2f, 24'hfa7d13, 24'h82c48d, 24'hbe9842,
    24'h5f4c21, 24'hd05c14, 24'h682e0a, 24'h341705, 24'he5f186, 24'h72f8c3, 24'hc68665,
    24'h9cb936, 24'h4e5c9b, 24'hd8d449, 24'h939020, 24'h49c810, 24'h24e408, 24'h127204,
    24'h093902, 24'h049c81, 24'hfdb444, 24'h7eda22, 24'h3f6d11, 24'he04c8c, 24'h702646,
    24'h381323, 24'he3f395, 24'h8e03ce, 24'h4701e7, 24'hdc7af7, 24'h91c77f, 24'hb719bb,
    24'ha476d9, 24'hadc168, 24'h56e0b4, 24'h2b705a, 24'h15b82d, 24'hf52612, 24'h7a9309,
    24'hc2b380, 24'h6159c0, 24'h30ace0, 24'h185670, 24'h0c2b38, 24'h06159c, 24'h030ace,
    24'h018567, 24'hff38b7, 24'h80665f, 24'hbfc92b, 24'ha01e91, 24'haff54c, 24'h57faa6,
    24'h2bfd53, 24'hea04ad, 24'h8af852, 24'h457c29, 24'hdd4410, 24'h6ea208, 24'h375104,
    24'h1ba882, 24'h0dd441, 24'hf91024, 24'h7c8812, 24'h3e4409, 24'he0d800, 24'h706c00,
    24'h383600, 24'h1c1b00, 24'h0e0d80, 24'h0706c0, 24'h038360, 24'h01c1b0, 24'h00e0d8,
    24'h00706c, 24'h003836, 24'h001c1b, 24'hfff409, 24'h800000, 24'h400000, 24'h200000,
    24'h100000, 24'h080000, 24'h040000, 24'h020000, 24'h010000, 24'h008000, 24'h004000,
    24'h002000, 24'h001000, 24'h000800, 24'h000400, 24'h000200, 24'h000100, 24'h000080,
    24'h000040, 24'h000020, 24'h000010, 24'h000008, 24'h000004, 24'h000002, 24'h000001
  };

  // Parity word of one bit position, zero past the frame end
  function automatic logic [SYN_W-1:0] crc_word(input logic [POS_W-1:0] idx);
    logic [SYN_W-1:0] w;
    w = '0;
    if (idx < POS_W'(FRAME_BITS)) begin
      w = CRC_TABLE[idx];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/mslcb_front.sv]
// ---------------------------------------------------------------------------
// Mode S LCB correction front end
// Classifies an incoming frame and looks up the parity words of its positions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mslcb_front (
  input  wire logic                              in_is_long,
  input  wire logic [mslcb_pkg::SYN_W-1:0]       in_syndrome,
  input  wire logic [mslcb_pkg::CNT_IN_W-1:0]    in_lcb_count,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_0,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_1,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_2,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_3,
  input  wire logic [mslcb_pkg::HALF_W-1:0]      in_frame_hi,
  input  wire logic [mslcb_pkg::HALF_W-1:0]      in_frame_lo,
  output mslcb_pkg::job_t                        job
);

  logic [mslcb_pkg::LCB_N-1:0][mslcb_pkg::POS_W-1:0] pos;
  logic out_of_range;
  logic too_many;

  assign pos = {in_lcb_pos_3, in_lcb_pos_2, in_lcb_pos_1, in_lcb_pos_0};

  // Flag any reported position that lies past the frame end
  always_comb begin
    out_of_range = 1'b0;
    for (int k = 0; k < mslcb_pkg::LCB_N; k++) begin
      if ((mslcb_pkg::CNT_IN_W'(k) < in_lcb_count) &&
          (pos[k] >= mslcb_pkg::POS_W'(mslcb_pkg::FRAME_BITS))) begin
        out_of_range = 1'b1;
      end
    end
  end

  assign too_many = (in_lcb_count > mslcb_pkg::CNT_IN_W'(mslcb_pkg::MAX_LCB)) ||
                    (in_lcb_count > mslcb_pkg::CNT_IN_W'(mslcb_pkg::LCB_N));

  // Build the request: resolve trivial cases here, leave the rest to the search
  always_comb begin
    job.search   = 1'b0;
    job.status   = mslcb_pkg::ST_NO_SOLUTION;
    job.count    = mslcb_pkg::CNT_W'(in_lcb_count);
    job.pos      = pos;
    job.syndrome = in_syndrome;
    job.hi       = in_frame_hi;
    job.lo       = in_frame_lo;
    for (int k = 0; k < mslcb_pkg::LCB_N; k++) begin
      job.words[k] = mslcb_pkg::crc_word(pos[k]);
    end
    priority if (in_syndrome == '0) begin
      job.status = mslcb_pkg::ST_NO_ERROR;
    end else if (too_many) begin
      job.status = mslcb_pkg::ST_TOO_MANY;
    end else if (!in_is_long || out_of_range || (in_lcb_count == '0)) begin
      job.status = mslcb_pkg::ST_NO_SOLUTION;
    end else begin
      job.search = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/mslcb_queue.sv]
// ---------------------------------------------------------------------------
// Mode S LCB correction request queue
// Short FIFO that decouples the front end from the search engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mode_s_lcb_brute_force_correct_unit_macros.svh"

module mslcb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mslcb_pkg::job_t  push_job,
  input  wire logic             pop,
  output mslcb_pkg::job_t       head,
  output logic                  head_valid,
  output logic                  full
);

  mslcb_pkg::job_t                  mem_r [mslcb_pkg::QDEPTH];
  logic [mslcb_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [mslcb_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [mslcb_pkg::QCNT_W-1:0]     cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == mslcb_pkg::QCNT_W'(mslcb_pkg::QDEPTH));

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `MSLCB_NEVER(a_q_overflow, clk, rst_n, push && full, "request pushed into full queue")
  `MSLCB_NEVER(a_q_underflow, clk, rst_n, pop && !head_valid, "request popped from empty queue")
  `MSLCB_ASSERT(a_q_bound, clk, rst_n, cnt_r <= mslcb_pkg::QCNT_W'(mslcb_pkg::QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

[hdl/mslcb_back.sv]
// ---------------------------------------------------------------------------
// Mode S LCB correction search engine
// Steps through position subsets one per cycle and emits the corrected frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mode_s_lcb_brute_force_correct_unit_macros.svh"

module mslcb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mslcb_pkg::job_t               head,
  input  wire logic                          head_valid,
  output logic                               pop,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [mslcb_pkg::SYN_W-1:0]        out_syndrome_out,
  output logic [mslcb_pkg::HALF_W-1:0]       out_fixed_hi,
  output logic [mslcb_pkg::HALF_W-1:0]       out_fixed_lo,
  output logic [mslcb_pkg::LCB_N-1:0]        out_flip_mask
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                                             state_r;
  logic [mslcb_pkg::LCB_N-1:0][mslcb_pkg::SYN_W-1:0]  words_r;
  logic [mslcb_pkg::LCB_N-1:0][mslcb_pkg::POS_W-1:0]  pos_r;
  logic [mslcb_pkg::SYN_W-1:0]                        syn_r;
  logic [mslcb_pkg::HALF_W-1:0]                       hi_r;
  logic [mslcb_pkg::HALF_W-1:0]                       lo_r;
  logic [mslcb_pkg::LCB_N-1:0]                        subset_r;
  logic [mslcb_pkg::LCB_N-1:0]                        last_r;
  logic [mslcb_pkg::LCB_N-1:0]                        answer_r;
  logic [1:0]                                         found_r;  // 0, 1, or 2 for many

  logic                                   out_valid_r;
  mslcb_pkg::status_t                     out_status_r;
  logic [mslcb_pkg::SYN_W-1:0]            out_syn_r;
  logic [mslcb_pkg::HALF_W-1:0]           out_hi_r;
  logic [mslcb_pkg::HALF_W-1:0]           out_lo_r;
  logic [mslcb_pkg::LCB_N-1:0]            out_mask_r;

  logic [mslcb_pkg::SYN_W-1:0]            acc;
  logic                                   hit;
  logic [mslcb_pkg::FRAME_BITS-1:0]       fixed;
  logic [mslcb_pkg::LCB_N-1:0]            last_nxt;

  assign pop = (state_r == S_IDLE) && head_valid;

  // Parity of the current subset
  always_comb begin
    acc = '0;
    for (int k = 0; k < mslcb_pkg::LCB_N; k++) begin
      if (subset_r[k]) begin
        acc = acc ^ words_r[k];
      end
    end
  end
  assign hit = (acc == syn_r);

  // Flip the bits of the winning subset
  always_comb begin
    fixed = {hi_r, lo_r};
    for (int k = 0; k < mslcb_pkg::LCB_N; k++) begin
      if (answer_r[k]) begin
        fixed[mslcb_pkg::POS_W'(mslcb_pkg::FRAME_BITS - 1) - pos_r[k]] =
          ~fixed[mslcb_pkg::POS_W'(mslcb_pkg::FRAME_BITS - 1) - pos_r[k]];
      end
    end
  end

  // Highest subset code for the request count
  assign last_nxt = mslcb_pkg::LCB_N'(((mslcb_pkg::LCB_N + 1)'(1) << head.count) - 1'b1);

  // Sequence load, scan and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= head_valid && !head.search;
          if (head_valid) begin
            words_r <= head.words;
            pos_r   <= head.pos;
            syn_r   <= head.syndrome;
            hi_r    <= head.hi;
            lo_r    <= head.lo;
            if (head.search) begin
              subset_r <= mslcb_pkg::LCB_N'(1);
              last_r   <= last_nxt;
              found_r  <= '0;
              answer_r <= '0;
              state_r  <= S_SCAN;
            end else begin
              out_status_r <= head.status;
              out_syn_r    <= head.syndrome;
              out_hi_r     <= head.hi;
              out_lo_r     <= head.lo;
              out_mask_r   <= '0;
            end
          end
        end
        S_SCAN: begin
          out_valid_r <= 1'b0;
          if (hit) begin
            answer_r <= subset_r;
            if (found_r != 2'd2) begin
              found_r <= found_r + 2'd1;
            end
          end
          if (subset_r == last_r) begin
            state_r <= S_FINISH;
          end else begin
            subset_r <= subset_r + 1'b1;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          priority if (found_r == 2'd2) begin
            out_status_r <= mslcb_pkg::ST_MULTIPLE;
            out_syn_r    <= syn_r;
            out_hi_r     <= hi_r;
            out_lo_r     <= lo_r;
            out_mask_r   <= '0;
          end else if (found_r == 2'd0) begin
            out_status_r <= mslcb_pkg::ST_NO_SOLUTION;
            out_syn_r    <= syn_r;
            out_hi_r     <= hi_r;
            out_lo_r     <= lo_r;
            out_mask_r   <= '0;
          end else begin
            out_status_r <= mslcb_pkg::ST_FOUND;
            out_syn_r    <= '0;
            out_hi_r     <= fixed[mslcb_pkg::FRAME_BITS-1 -: mslcb_pkg::HALF_W];
            out_lo_r     <= fixed[mslcb_pkg::HALF_W-1:0];
            out_mask_r   <= answer_r;
          end
          state_r <= S_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_syndrome_out = out_syn_r;
  assign out_fixed_hi     = out_hi_r;
  assign out_fixed_lo     = out_lo_r;
  assign out_flip_mask    = out_mask_r;

  `MSLCB_ASSERT(a_found_clears, clk, rst_n, (out_valid_r && (out_status_r == mslcb_pkg::ST_FOUND)) |-> ((out_syn_r == '0) && (out_mask_r != '0)), "solution without cleared syndrome or mask")
  `MSLCB_ASSERT(a_mask_only_found, clk, rst_n, (out_valid_r && (out_status_r != mslcb_pkg::ST_FOUND)) |-> (out_mask_r == '0), "flip mask set without solution")
  `MSLCB_ASSERT(a_scan_nonzero, clk, rst_n, (state_r == S_SCAN) |-> ((subset_r != '0) && (subset_r <= last_r)), "subset code out of range during scan")
  `MSLCB_ASSERT(a_finish_emits, clk, rst_n, (state_r == S_FINISH) |=> out_valid_r, "finished search without result")

endmodule

`default_nettype wire

[hdl/mode_s_lcb_brute_force_correct_unit.sv]
// ---------------------------------------------------------------------------
// Mode S low-confidence-bit brute-force corrector
// Repairs a long Mode S frame by trying every subset of its weak bit positions.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Up to two requests
// wait in a queue ahead of the search engine, and busy is high only while that
// queue is full. Each request yields exactly one result, shown for a single
// cycle with out_valid; the receiver cannot stall, so it must capture the
// result in that cycle. Frames settled at once (zero syndrome, too many
// positions, short frame, position past the frame end, no positions) give
// their result from the search engine without a search, once it is idle. A
// searched frame is loaded into the engine, which then makes one subset parity
// compare per cycle in its scan loop over every nonempty subset of its n
// positions, and then registers the result in a finish step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mode_s_lcb_brute_force_correct_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_is_long,
  input  wire logic [mslcb_pkg::SYN_W-1:0]       in_syndrome,
  input  wire logic [mslcb_pkg::CNT_IN_W-1:0]    in_lcb_count,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_0,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_1,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_2,
  input  wire logic [mslcb_pkg::POS_W-1:0]       in_lcb_pos_3,
  input  wire logic [mslcb_pkg::HALF_W-1:0]      in_frame_hi,
  input  wire logic [mslcb_pkg::HALF_W-1:0]      in_frame_lo,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [mslcb_pkg::SYN_W-1:0]            out_syndrome_out,
  output logic [mslcb_pkg::HALF_W-1:0]           out_fixed_hi,
  output logic [mslcb_pkg::HALF_W-1:0]           out_fixed_lo,
  output logic [mslcb_pkg::LCB_N-1:0]            out_flip_mask
);

  mslcb_pkg::job_t front_job;
  mslcb_pkg::job_t head_job;
  logic            head_valid;
  logic            q_full;
  logic            q_pop;
  logic            push;

  // Accept a request whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the request
  mslcb_front u_front (
    .in_is_long   (in_is_long),
    .in_syndrome  (in_syndrome),
    .in_lcb_count (in_lcb_count),
    .in_lcb_pos_0 (in_lcb_pos_0),
    .in_lcb_pos_1 (in_lcb_pos_1),
    .in_lcb_pos_2 (in_lcb_pos_2),
    .in_lcb_pos_3 (in_lcb_pos_3),
    .in_frame_hi  (in_frame_hi),
    .in_frame_lo  (in_frame_lo),
    .job          (front_job)
  );

  // Hold requests between front end and search engine
  mslcb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (front_job),
    .pop        (q_pop),
    .head       (head_job),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Search subsets and drive results
  mslcb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head_job),
    .head_valid       (head_valid),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_syndrome_out (out_syndrome_out),
    .out_fixed_hi     (out_fixed_hi),
    .out_fixed_lo     (out_fixed_lo),
    .out_flip_mask    (out_flip_mask)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
// ---------------------------------------------------------------------------
// Mode S LCB corrector testbench
// Sends Mode S frame requests to the corrector and checks each strobed result
// against a built-in prediction of the subset search. The parity table is
// rebuilt from the generator polynomial. Directed frames come first, then
// random well-formed and malformed frames under several sender idle rates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mslcb_pkg::*;

  // One frame request as driven on the in_ ports
  typedef struct {
    logic             is_long;
    logic [SYN_W-1:0] syndrome;
    logic [3:0]       count;
    logic [POS_W-1:0] pos [LCB_N];
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } frame_req_t;

  // Predicted correction for one request
  typedef struct {
    status_t           status;
    logic [SYN_W-1:0]  syndrome;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
    logic [LCB_N-1:0]  mask;
  } fix_t;

  class correction_scoreboard;
    logic [SYN_W-1:0] parity [FRAME_BITS];
    fix_t             pending_fixes [$];
    int unsigned      errors;

    // Build the parity word of each bit position from the generator polynomial
    function new();
      logic [SYN_W:0] w;
      errors = 0;
      parity[FRAME_BITS-1] = 24'h000001;
      for (int i = FRAME_BITS - 2; i >= 0; i--) begin
        w = {parity[i+1], 1'b0};
        parity[i] = w[SYN_W] ? (w[SYN_W-1:0] ^ 24'hfff409) : w[SYN_W-1:0];
      end
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Search every nonempty subset of the weak positions in ascending subset code order
    function fix_t correct_frame(frame_req_t r);
      fix_t             f;
      int unsigned      hits;
      logic [LCB_N-1:0] pick;
      logic [SYN_W-1:0] acc;
      int               bit_idx;
      f.status   = ST_NO_ERROR;
      f.syndrome = r.syndrome;
      f.hi       = r.hi;
      f.lo       = r.lo;
      f.mask     = '0;
      if (r.syndrome == '0) return f;
      if (r.count > MAX_LCB || r.count > LCB_N) begin
        f.status = ST_TOO_MANY;
        return f;
      end
      f.status = ST_NO_SOLUTION;
      if (!r.is_long) return f;
      for (int k = 0; k < r.count; k++) begin
        if (r.pos[k] >= FRAME_BITS) return f;
      end
      hits = 0;
      pick = '0;
      for (int s = 1; s < (1 << r.count); s++) begin
        acc = '0;
        for (int k = 0; k < r.count; k++) begin
          if (s[k]) acc ^= parity[r.pos[k]];
        end
        if (acc == r.syndrome) begin
          hits++;
          pick = s[LCB_N-1:0];
        end
      end
      if (hits > 1) begin
        f.status = ST_MULTIPLE;
        return f;
      end
      if (hits == 0) return f;
      // Flip the matched bits; bit 0 sits in the top place of the high half
      for (int k = 0; k < r.count; k++) begin
        if (pick[k]) begin
          bit_idx = r.pos[k];
          if (bit_idx < HALF_W) f.hi[HALF_W-1-bit_idx] = ~f.hi[HALF_W-1-bit_idx];
          else f.lo[FRAME_BITS-1-bit_idx] = ~f.lo[FRAME_BITS-1-bit_idx];
        end
      end
      f.status   = ST_FOUND;
      f.syndrome = '0;
      f.mask     = pick;
      return f;
    endfunction

    function void note_request(frame_req_t r);
      pending_fixes.push_back(correct_frame(r));
    endfunction

    function int unsigned pending();
      return pending_fixes.size();
    endfunction

    // Compare one strobed result with the oldest prediction
    task check_result(logic [2:0] status, logic [SYN_W-1:0] syndrome,
                      logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
                      logic [LCB_N-1:0] mask);
      fix_t e;
      if (pending_fixes.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      e = pending_fixes.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, want %0d", status, e.status));
      if (syndrome !== e.syndrome)
        report($sformatf("syndrome_out %06h, want %06h", syndrome, e.syndrome));
      if (hi !== e.hi)
        report($sformatf("fixed_hi %014h, want %014h", hi, e.hi));
      if (lo !== e.lo)
        report($sformatf("fixed_lo %014h, want %014h", lo, e.lo));
      if (mask !== e.mask)
        report($sformatf("flip_mask %h, want %h", mask, e.mask));
    endtask

    task check_drained();
      if (pending_fixes.size() != 0)
        report($sformatf("%0d results never arrived", pending_fixes.size()));
    endtask
  endclass

  localparam int RANDOM_PER_PHASE = 325;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_is_long;
  logic [SYN_W-1:0]    in_syndrome;
  logic [CNT_IN_W-1:0] in_lcb_count;
  logic [POS_W-1:0]    in_lcb_pos_0;
  logic [POS_W-1:0]    in_lcb_pos_1;
  logic [POS_W-1:0]    in_lcb_pos_2;
  logic [POS_W-1:0]    in_lcb_pos_3;
  logic [HALF_W-1:0]   in_frame_hi;
  logic [HALF_W-1:0]   in_frame_lo;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [SYN_W-1:0]    out_syndrome_out;
  logic [HALF_W-1:0]   out_fixed_hi;
  logic [HALF_W-1:0]   out_fixed_lo;
  logic [LCB_N-1:0]    out_flip_mask;

  correction_scoreboard sb;

  mode_s_lcb_brute_force_correct_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_is_long       (in_is_long),
    .in_syndrome      (in_syndrome),
    .in_lcb_count     (in_lcb_count),
    .in_lcb_pos_0     (in_lcb_pos_0),
    .in_lcb_pos_1     (in_lcb_pos_1),
    .in_lcb_pos_2     (in_lcb_pos_2),
    .in_lcb_pos_3     (in_lcb_pos_3),
    .in_frame_hi      (in_frame_hi),
    .in_frame_lo      (in_frame_lo),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_syndrome_out (out_syndrome_out),
    .out_fixed_hi     (out_fixed_hi),
    .out_fixed_lo     (out_fixed_lo),
    .out_flip_mask    (out_flip_mask)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_syndrome_out, out_fixed_hi, out_fixed_lo, out_flip_mask);
  end

  function automatic logic [HALF_W-1:0] rand56();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[HALF_W-1:0];
  endfunction

  function automatic frame_req_t make_frame(logic is_long, logic [SYN_W-1:0] syndrome,
                                            logic [3:0] count, logic [POS_W-1:0] p0,
                                            logic [POS_W-1:0] p1, logic [POS_W-1:0] p2,
                                            logic [POS_W-1:0] p3, logic [HALF_W-1:0] hi,
                                            logic [HALF_W-1:0] lo);
    frame_req_t r;
    r.is_long  = is_long;
    r.syndrome = syndrome;
    r.count    = count;
    r.pos[0]   = p0;
    r.pos[1]   = p1;
    r.pos[2]   = p2;
    r.pos[3]   = p3;
    r.hi       = hi;
    r.lo       = lo;
    return r;
  endfunction

  // Mostly well-formed long frames with weak positions, the rest noise
  function automatic frame_req_t random_frame();
    frame_req_t       r;
    int               kind;
    logic [LCB_N-1:0] flips;
    kind = $urandom_range(99);
    r.is_long = 1'b1;
    r.count   = $urandom_range(1, LCB_N);
    r.hi      = rand56();
    r.lo      = rand56();
    for (int k = 0; k < LCB_N; k++) r.pos[k] = $urandom_range(FRAME_BITS - 1);
    if (kind < 55) begin
      // solvable: syndrome from a random nonempty subset
      flips = $urandom_range(1, (1 << r.count) - 1);
      r.syndrome = '0;
      for (int k = 0; k < r.count; k++) begin
        if (flips[k]) r.syndrome ^= sb.parity[r.pos[k]];
      end
    end else if (kind < 65) begin
      // ambiguous: repeat a position so two subsets match
      r.count    = $urandom_range(2, LCB_N);
      r.pos[1]   = r.pos[0];
      r.syndrome = sb.parity[r.pos[0]];
    end else if (kind < 75) begin
      r.syndrome = $urandom;
    end else begin
      r.is_long  = $urandom_range(1);
      r.syndrome = ($urandom_range(7) == 0) ? '0 : $urandom;
      r.count    = $urandom_range(15);
      for (int k = 0; k < LCB_N; k++) r.pos[k] = $urandom_range(127);
    end
    return r;
  endfunction

  // Drive one request at the falling edge and hold it until taken
  task send_frame(frame_req_t r, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start        = 1'b1;
    in_is_long   = r.is_long;
    in_syndrome  = r.syndrome;
    in_lcb_count = r.count;
    in_lcb_pos_0 = r.pos[0];
    in_lcb_pos_1 = r.pos[1];
    in_lcb_pos_2 = r.pos[2];
    in_lcb_pos_3 = r.pos[3];
    in_frame_hi  = r.hi;
    in_frame_lo  = r.lo;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    @(negedge clk);
  endtask

  initial begin
    int           idle_pct [4];
    frame_req_t   directed [$];
    logic [SYN_W-1:0] s4;
    logic [HALF_W-1:0] ones;

    sb = new();
    idle_pct = '{0, 84, 0, 16};
    ones = '1;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_is_long   = 1'b0;
    in_syndrome  = '0;
    in_lcb_count = '0;
    in_lcb_pos_0 = '0;
    in_lcb_pos_1 = '0;
    in_lcb_pos_2 = '0;
    in_lcb_pos_3 = '0;
    in_frame_hi  = '0;
    in_frame_lo  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Zero syndrome wins over everything else
    directed.push_back(make_frame(1, '0, 15, 127, 127, 127, 127, ones, ones));
    directed.push_back(make_frame(0, '0, 0, 0, 0, 0, 0, '0, '0));
    // Too many positions, checked before the short-frame case
    directed.push_back(make_frame(1, 24'h000001, 5, 1, 2, 3, 4, rand56(), rand56()));
    directed.push_back(make_frame(0, 24'hffffff, 15, 0, 0, 0, 0, ones, '0));
    // Short frame even when a subset would match
    directed.push_back(make_frame(0, sb.parity[0], 1, 0, 0, 0, 0, rand56(), rand56()));
    // Position past the frame end within the count
    directed.push_back(make_frame(1, 24'h000001, 1, 112, 0, 0, 0, rand56(), rand56()));
    directed.push_back(make_frame(1, sb.parity[5], 4, 5, 6, 7, 127, rand56(), rand56()));
    // Junk positions beyond the count are ignored
    directed.push_back(make_frame(1, sb.parity[111], 1, 111, 127, 127, 127, ones, ones));
    // No positions with a nonzero syndrome
    directed.push_back(make_frame(1, 24'h123456, 0, 0, 0, 0, 0, rand56(), rand56()));
    // Single-bit fixes at both ends and across the half boundary
    directed.push_back(make_frame(1, sb.parity[0], 1, 0, 0, 0, 0, ones, ones));
    directed.push_back(make_frame(1, sb.parity[55], 1, 55, 0, 0, 0, '0, '0));
    directed.push_back(make_frame(1, sb.parity[56], 1, 56, 0, 0, 0, '0, ones));
    directed.push_back(make_frame(1, sb.parity[111], 2, 111, 0, 0, 0, rand56(), rand56()));
    // Four positions: the full subset, then two- and three-bit subsets
    s4 = sb.parity[3] ^ sb.parity[40] ^ sb.parity[70] ^ sb.parity[100];
    directed.push_back(make_frame(1, s4, 4, 3, 40, 70, 100, rand56(), rand56()));
    directed.push_back(make_frame(1, sb.parity[20] ^ sb.parity[40], 4, 10, 20, 30, 40,
                                  rand56(), rand56()));
    directed.push_back(make_frame(1, sb.parity[60] ^ sb.parity[61] ^ sb.parity[62], 4,
                                  60, 61, 62, 63, rand56(), rand56()));
    // Ambiguous: repeated positions give several matching subsets
    directed.push_back(make_frame(1, sb.parity[7], 2, 7, 7, 0, 0, rand56(), rand56()));
    directed.push_back(make_frame(1, sb.parity[50], 4, 50, 50, 50, 50, rand56(), rand56()));
    // No subset matches
    directed.push_back(make_frame(1, 24'h000003, 4, 88, 89, 90, 91, rand56(), rand56()));
    directed.push_back(make_frame(1, 24'hffffff, 4, 108, 109, 110, 111, ones, ones));

    foreach (directed[i]) send_frame(directed[i], 0);

    // Hold off until every directed result has come back
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    foreach (idle_pct[ph]) begin
      repeat (RANDOM_PER_PHASE) send_frame(random_frame(), idle_pct[ph]);
    end
    start = 1'b0;

    // Drain, then allow for one more full search
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
